### hw/rtl/hgbd_pkg.sv
package hgbd_pkg;

    localparam int StackDepth   = 32;
    localparam int SymbolDepth  = 1024;
    localparam int RuleDepth    = 1024;
    localparam int StreamBytes  = 65536;
    localparam int MaxLen       = 16;

    localparam int StackAw  = $clog2(StackDepth);
    localparam int SymAw    = $clog2(SymbolDepth);
    localparam int RuleAw   = $clog2(RuleDepth);
    localparam int StreamAw = $clog2(StreamBytes);

    localparam logic [16:0] CodeSat = 17'h1FFFF;
    localparam logic [10:0] IdxSat  = 11'h7FF;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatCorrupt = 2'd1;
    localparam logic [1:0] StatRange   = 2'd2;

    localparam logic [2:0] ModeCount  = 3'd0;
    localparam logic [2:0] ModeSymbol = 3'd1;
    localparam logic [2:0] ModeRule   = 3'd2;
    localparam logic [2:0] ModeStream = 3'd3;
    localparam logic [2:0] ModeFinal  = 3'd4;
    localparam logic [2:0] ModeSeek   = 3'd5;
    localparam logic [2:0] ModeNext   = 3'd6;

    localparam logic RegRuleCount   = 1'b0;
    localparam logic RegSymbolCount = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FINAL,
        ST_POP,
        ST_POP_WAIT,
        ST_BIT_RD,
        ST_BIT_WAIT,
        ST_SYM_WAIT,
        ST_CHECK,
        ST_RULE_WAIT,
        ST_PUSH_L,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/huffman_grammar_byte_decoder.sv
// Canonical Huffman / pair-rule byte decoder. Issue a command with start
// while busy is low; exactly one result comes back on data_byte/status
// with done high for one cycle, and it must be taken then: there is no
// way to hold it off. Finalize handles one code length per cycle. A
// next-byte request goes through entry and report states, plus a bit read
// and wait per stream bit (one stream memory read each), a symbol table
// read and its check, a check, rule fetch and push per rule expansion,
// and a pop, stack read and check per stack pop, since the symbol, rule,
// stream and stack tables live in single-port-read synchronous RAM.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant for idle time.
module huffman_grammar_byte_decoder
    import hgbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [15:0] index,
    input  logic [15:0] value_a,
    input  logic [15:0] value_b,
    input  logic [18:0] bit_position,
    output logic        done,
    output logic [7:0]  data_byte,
    output logic [1:0]  status
);

    // configuration
    logic [10:0] rule_count_reg, symbol_count_reg;

    // small tables in flops (read at a counter position)
    logic [10:0] len_cnt_reg   [MaxLen];
    logic [16:0] first_code_reg[MaxLen];
    logic [10:0] first_idx_reg [MaxLen];

    state_t      state_reg, state_next;
    logic [2:0]  mode_reg;
    logic [15:0] index_reg, va_reg, vb_reg;
    logic [19:0] cursor_reg, cursor_next;  // one extra bit: may sit past memory
    logic [StackAw:0] sp_reg, sp_next;
    logic [16:0] code_reg, code_next;
    logic [4:0]  len_reg, len_next;   // 0-based length - 1 during decode
    logic [17:0] fcode_reg, fcode_next;
    logic [11:0] fidx_reg, fidx_next;
    logic [14:0] sum_reg, sum_next;   // 16 counts of up to 2047
    logic [15:0] sym_reg, sym_next;
    logic [7:0]  data_reg, data_next;
    logic [1:0]  stat_reg, stat_next;
    logic        done_reg, done_next;

    // memories
    logic                sym_we;
    logic [SymAw-1:0]    sym_waddr, sym_raddr;
    logic [15:0]         sym_rdata;
    logic                rule_we;
    logic [RuleAw-1:0]   rule_waddr, rule_raddr;
    logic [31:0]         rule_rdata;
    logic                str_we;
    logic [StreamAw-1:0] str_waddr, str_raddr;
    logic [7:0]          str_rdata;
    logic                stk_we;
    logic [StackAw-1:0]  stk_waddr, stk_raddr;
    logic [15:0]         stk_wdata, stk_rdata;

    hgbd_ram #(.Width(16), .Depth(SymbolDepth)) u_sym (
        .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(va_reg),
        .raddr(sym_raddr), .rdata(sym_rdata));
    hgbd_ram #(.Width(32), .Depth(RuleDepth)) u_rule (
        .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata({vb_reg, va_reg}),
        .raddr(rule_raddr), .rdata(rule_rdata));
    hgbd_ram #(.Width(8), .Depth(StreamBytes)) u_str (
        .clk(clk), .we(str_we), .waddr(str_waddr), .wdata(va_reg[7:0]),
        .raddr(str_raddr), .rdata(str_rdata));
    hgbd_ram #(.Width(16), .Depth(StackDepth)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign data_byte = data_reg;
    assign status    = stat_reg;

    // decode helpers
    logic [3:0]  len_i;
    logic [10:0] cnt_cur;
    logic [16:0] fc_cur;
    logic [10:0] fi_cur;
    logic        bit_in;
    logic [16:0] code_new;
    logic [16:0] diff;
    logic        hit;
    logic [11:0] sym_idx;
    logic [15:0] rule_num;
    logic [31:0] stream_bits;

    assign len_i       = len_reg[3:0];
    assign cnt_cur     = len_cnt_reg[len_i];
    assign fc_cur      = first_code_reg[len_i];
    assign fi_cur      = first_idx_reg[len_i];
    assign bit_in      = str_rdata[3'd7 - cursor_reg[2:0]];
    assign code_new    = {code_reg[15:0], bit_in};
    assign diff        = code_new - fc_cur;
    assign hit         = (cnt_cur != 11'd0) && (code_new >= fc_cur)
                         && (diff < {6'd0, cnt_cur});
    assign sym_idx     = {1'b0, fi_cur} + diff[11:0];
    assign rule_num    = sym_reg - 16'd256;
    assign stream_bits = 32'(StreamBytes) * 32'd8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg   <= '0;
            symbol_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == RegRuleCount)
            begin
                rule_count_reg <= cfg_data;
            end
            else
            begin
                symbol_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            sp_reg      <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < MaxLen; i++)
            begin
                len_cnt_reg[i]    <= '0;
                first_code_reg[i] <= '0;
                first_idx_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            sp_reg     <= sp_next;
            done_reg   <= done_next;
            if (state_reg == ST_IDLE && start && mode == ModeCount
                && index >= 16'd1 && index <= 16'(MaxLen))
            begin
                len_cnt_reg[4'(index - 16'd1)] <=
                    (value_a > 16'(IdxSat)) ? IdxSat : value_a[10:0];
            end
            if (state_reg == ST_FINAL)
            begin
                first_code_reg[len_i] <= fcode_reg[16:0];
                first_idx_reg[len_i]  <= fidx_reg[10:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            mode_reg  <= mode;
            index_reg <= index;
            va_reg    <= value_a;
            vb_reg    <= value_b;
        end
        code_reg    <= code_next;
        len_reg     <= len_next;
        fcode_reg   <= fcode_next;
        fidx_reg    <= fidx_next;
        sum_reg     <= sum_next;
        sym_reg     <= sym_next;
        data_reg    <= data_next;
        stat_reg    <= stat_next;
    end

    always_comb
    begin
        logic [18:0] c_add;
        logic [11:0] i_add;
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        sp_next      = sp_reg;
        code_next    = code_reg;
        len_next     = len_reg;
        fcode_next   = fcode_reg;
        fidx_next    = fidx_reg;
        sum_next     = sum_reg;
        sym_next     = sym_reg;
        data_next    = data_reg;
        stat_next    = stat_reg;
        done_next    = 1'b0;
        sym_we       = 1'b0;
        sym_waddr    = index_reg[SymAw-1:0];
        sym_raddr    = sym_idx[SymAw-1:0];
        rule_we      = 1'b0;
        rule_waddr   = index_reg[RuleAw-1:0];
        rule_raddr   = rule_num[RuleAw-1:0];
        str_we       = 1'b0;
        str_waddr    = index_reg[StreamAw-1:0];
        str_raddr    = cursor_reg[StreamAw+2:3];
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[StackAw-1:0];
        stk_wdata    = rule_rdata[31:16];
        stk_raddr    = StackAw'(sp_reg - 1'b1);
        c_add        = '0;
        i_add        = '0;

        case (state_reg)
        ST_IDLE:
        begin
            if (start)
            begin
                data_next  = '0;
                stat_next  = StatOk;
                state_next = ST_DONE;
                case (mode)
                ModeCount:
                begin
                    if (!(index >= 16'd1 && index <= 16'(MaxLen)))
                    begin
                        stat_next = StatRange;
                    end
                end
                ModeSymbol:
                begin
                    if (32'(index) >= 32'(SymbolDepth))
                    begin
                        stat_next = StatRange;
                    end
                end
                ModeRule:
                begin
                    if (32'(index) >= 32'(RuleDepth))
                    begin
                        stat_next = StatRange;
                    end
                end
                ModeStream:
                begin
                    if (32'(index) >= 32'(StreamBytes))
                    begin
                        stat_next = StatRange;
                    end
                end
                ModeFinal:
                begin
                    len_next   = '0;
                    fcode_next = '0;
                    fidx_next  = '0;
                    sum_next   = '0;
                    state_next = ST_FINAL;
                end
                ModeSeek:
                begin
                    cursor_next = {1'b0, bit_position};
                    sp_next     = '0;
                end
                ModeNext:
                begin
                    state_next = ST_POP;
                end
                default:
                begin
                end
                endcase
            end
        end
        ST_FINAL:
        begin
            // table entry written from fcode/fidx in the clocked block
            i_add = fidx_reg + {1'b0, cnt_cur};
            fidx_next = (i_add > {1'b0, IdxSat}) ? {1'b0, IdxSat} : i_add;
            sum_next  = sum_reg + {4'd0, cnt_cur};
            c_add = ({1'b0, fcode_reg} + {8'd0, cnt_cur}) << 1;
            fcode_next = (c_add > {2'b0, CodeSat}) ? {1'b0, CodeSat} : c_add[17:0];
            len_next = len_reg + 5'd1;
            if (len_reg == 5'(MaxLen - 1))
            begin
                stat_next  = (sum_next == {4'd0, symbol_count_reg})
                             ? StatOk : StatCorrupt;
                state_next = ST_DONE;
            end
        end
        ST_POP:
        begin
            if (sp_reg != '0)
            begin
                sp_next    = sp_reg - 1'b1;
                state_next = ST_POP_WAIT;
            end
            else
            begin
                code_next  = '0;
                len_next   = '0;
                state_next = ST_BIT_RD;
            end
        end
        ST_POP_WAIT:
        begin
            sym_next   = stk_rdata;
            state_next = ST_CHECK;
        end
        ST_BIT_RD:
        begin
            if (32'(cursor_reg) >= stream_bits)
            begin
                stat_next  = StatCorrupt;
                state_next = ST_DONE;
            end
            else
            begin
                state_next = ST_BIT_WAIT;
            end
        end
        ST_BIT_WAIT:
        begin
            cursor_next = cursor_reg + 20'd1;
            code_next   = code_new;
            if (hit)
            begin
                if (sym_idx >= {1'b0, symbol_count_reg}
                    || 32'(sym_idx) >= 32'(SymbolDepth))
                begin
                    stat_next  = StatCorrupt;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SYM_WAIT;
                end
            end
            else if (len_reg == 5'(MaxLen - 1))
            begin
                stat_next  = StatCorrupt;
                state_next = ST_DONE;
            end
            else
            begin
                len_next   = len_reg + 5'd1;
                state_next = ST_BIT_RD;
            end
        end
        ST_SYM_WAIT:
        begin
            sym_next   = sym_rdata;
            state_next = ST_CHECK;
        end
        ST_CHECK:
        begin
            if (sym_reg < 16'd256)
            begin
                data_next  = sym_reg[7:0];
                state_next = ST_DONE;
            end
            else if ({5'd0, rule_num} >= {10'd0, rule_count_reg}
                     || 32'(rule_num) >= 32'(RuleDepth)
                     || 32'(sp_reg) + 32'd2 > 32'(StackDepth))
            begin
                stat_next  = StatCorrupt;
                state_next = ST_DONE;
            end
            else
            begin
                state_next = ST_RULE_WAIT;
            end
        end
        ST_RULE_WAIT:
        begin
            // right child goes first, left on top
            stk_we     = 1'b1;
            stk_wdata  = rule_rdata[31:16];
            sym_next   = rule_rdata[15:0];
            sp_next    = sp_reg + 1'b1;
            state_next = ST_PUSH_L;
        end
        ST_PUSH_L:
        begin
            // left child is popped at once: skip the write/read round trip
            state_next = ST_CHECK;
        end
        ST_DONE:
        begin
            if (mode_reg == ModeSymbol && stat_reg == StatOk)
            begin
                sym_we = 1'b1;
            end
            if (mode_reg == ModeRule && stat_reg == StatOk)
            begin
                rule_we = 1'b1;
            end
            if (mode_reg == ModeStream && stat_reg == StatOk)
            begin
                str_we = 1'b1;
            end
            if (stat_reg != StatOk)
            begin
                data_next = '0;
            end
            done_next  = 1'b1;
            state_next = ST_IDLE;
        end
        default:
        begin
            state_next = ST_IDLE;
        end
        endcase
    end

endmodule

### hw/rtl/hgbd_ram.sv
module hgbd_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
